### rtl/sceq_pkg.sv
package sceq_pkg;

    // Request codes
    localparam logic [1:0] REQ_EMIT = 2'd0;
    localparam logic [1:0] REQ_POP  = 2'd1;
    localparam logic [1:0] REQ_GET  = 2'd2;

    localparam int unsigned SEQ_W   = 32;
    localparam int unsigned TICK_W  = 32;
    localparam int unsigned SPEED_W = 16;
    localparam int unsigned PEND_W  = 5;

    // Link status as recorded in the ring and used for duplicate suppression
    typedef struct packed {
        logic               present;
        logic               initialized;
        logic               link_up;
        logic [SPEED_W-1:0] speed;
    } status_t;

    // One ring entry
    typedef struct packed {
        logic [SEQ_W-1:0]  seq;
        logic [TICK_W-1:0] tick;
        status_t           status;
    } entry_t;

endpackage

### rtl/sceq_ring_ram.sv
module sceq_ring_ram #(
    parameter int unsigned DEPTH  = 16,
    parameter int unsigned ADDR_W = $clog2(DEPTH)
) (
    input  logic                 aclk,
    input  logic                 wr_en,
    input  logic [ADDR_W-1:0]    wr_addr,
    input  sceq_pkg::entry_t     wr_data,
    input  logic [ADDR_W-1:0]    rd_addr,
    output sceq_pkg::entry_t     rd_data
);
    import sceq_pkg::*;

    entry_t mem [DEPTH];
    entry_t rd_data_reg;

    // One write port, one registered read port
    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
        rd_data_reg <= mem[rd_addr];
    end

    assign rd_data = rd_data_reg;

endmodule

### rtl/status_change_event_queue_top.sv
// Sequence of states: emit, unused code, or pop/get-after on an empty ring go IDLE then DONE;
// pop goes IDLE, POP, DONE; get-after goes IDLE, SCAN, DONE, scanning 1 to held count entries,
// one entry per cycle through the ring RAM. One word at a time: a new word is taken once
// the previous one has moved to the output register.
// Reset (aresetn low, synchronous) empties the ring and clears sequence, drop and
// last-status state; ring RAM contents are not cleared.
module status_change_event_queue_top #(
    parameter int unsigned QUEUE_DEPTH = 16
) (
    input  logic                           aclk,
    input  logic                           aresetn,

    input  logic                           s_valid,
    output logic                           s_ready,
    input  logic [1:0]                     s_req_type,
    input  logic                           s_dev_present,
    input  logic                           s_dev_initialized,
    input  logic                           s_link_is_up,
    input  logic [sceq_pkg::SPEED_W-1:0]   s_link_speed,
    input  logic [sceq_pkg::TICK_W-1:0]    s_now_tick,
    input  logic [sceq_pkg::SEQ_W-1:0]     s_after_seq,

    output logic                           m_valid,
    input  logic                           m_ready,
    output logic                           m_ok,
    output logic [sceq_pkg::SEQ_W-1:0]     m_entry_seq,
    output logic [sceq_pkg::TICK_W-1:0]    m_entry_tick,
    output logic                           m_entry_present,
    output logic                           m_entry_initialized,
    output logic                           m_entry_link_up,
    output logic [sceq_pkg::SPEED_W-1:0]   m_entry_speed,
    output logic [sceq_pkg::PEND_W-1:0]    m_pending_count,
    output logic [sceq_pkg::SEQ_W-1:0]     m_dropped_total,
    output logic [sceq_pkg::SEQ_W-1:0]     m_latest_sequence
);
    import sceq_pkg::*;

    localparam int unsigned PTR_W = $clog2(QUEUE_DEPTH);
    localparam int unsigned CNT_W = $clog2(QUEUE_DEPTH + 1);
    localparam int unsigned SUM_W = CNT_W + 1;

    localparam logic [1:0] ST_IDLE = 2'd0;
    localparam logic [1:0] ST_POP  = 2'd1;
    localparam logic [1:0] ST_SCAN = 2'd2;
    localparam logic [1:0] ST_DONE = 2'd3;

    function automatic logic [PTR_W-1:0] next_pos(input logic [PTR_W-1:0] p);
        logic [PTR_W-1:0] r;
        if (p == PTR_W'(QUEUE_DEPTH - 1)) begin
            r = '0;
        end else begin
            r = p + PTR_W'(1);
        end
        return r;
    endfunction

    // Control state
    logic [1:0]        state_reg, state_next;
    logic [PTR_W-1:0]  write_pos_reg, write_pos_next;
    logic [PTR_W-1:0]  read_pos_reg, read_pos_next;
    logic [CNT_W-1:0]  held_count_reg, held_count_next;
    logic [SEQ_W-1:0]  drop_counter_reg, drop_counter_next;
    logic [SEQ_W-1:0]  seq_counter_reg, seq_counter_next;
    logic              last_known_reg, last_known_next;
    status_t           last_status_reg, last_status_next;
    logic [PTR_W-1:0]  scan_idx_reg, scan_idx_next;
    logic [CNT_W-1:0]  scan_left_reg, scan_left_next;
    logic              m_valid_reg, m_valid_next;

    // Payload
    logic [SEQ_W-1:0]  cursor_reg, cursor_next;
    logic              res_ok_reg, res_ok_next;
    entry_t            res_entry_reg, res_entry_next;
    logic              m_ok_reg, m_ok_next;
    entry_t            m_entry_reg, m_entry_next;
    logic [PEND_W-1:0] m_pending_reg, m_pending_next;
    logic [SEQ_W-1:0]  m_dropped_reg, m_dropped_next;
    logic [SEQ_W-1:0]  m_latest_reg, m_latest_next;

    // RAM ports
    logic              ram_wr_en;
    entry_t            ram_wr_data;
    logic [PTR_W-1:0]  ram_rd_addr;
    entry_t            ram_rd_data;

    status_t           status_in;
    logic              is_dup;
    logic              is_full;

    sceq_ring_ram #(
        .DEPTH  (QUEUE_DEPTH),
        .ADDR_W (PTR_W)
    ) u_ring (
        .aclk    (aclk),
        .wr_en   (ram_wr_en),
        .wr_addr (write_pos_reg),
        .wr_data (ram_wr_data),
        .rd_addr (ram_rd_addr),
        .rd_data (ram_rd_data)
    );

    assign status_in = '{present:     s_dev_present,
                         initialized: s_dev_initialized,
                         link_up:     s_link_is_up,
                         speed:       s_link_speed};
    assign is_dup  = last_known_reg && (last_status_reg == status_in);
    assign is_full = (held_count_reg == CNT_W'(QUEUE_DEPTH));

    assign ram_wr_data = '{seq:    seq_counter_reg + SEQ_W'(1),
                           tick:   s_now_tick,
                           status: status_in};
    // Oldest entry while idle, scan pointer otherwise
    assign ram_rd_addr = (state_reg == ST_IDLE) ? read_pos_reg : scan_idx_reg;

    assign s_ready = (state_reg == ST_IDLE);

    // Request sequencer
    always_comb begin
        state_next        = state_reg;
        write_pos_next    = write_pos_reg;
        read_pos_next     = read_pos_reg;
        held_count_next   = held_count_reg;
        drop_counter_next = drop_counter_reg;
        seq_counter_next  = seq_counter_reg;
        last_known_next   = last_known_reg;
        last_status_next  = last_status_reg;
        scan_idx_next     = scan_idx_reg;
        scan_left_next    = scan_left_reg;
        cursor_next       = cursor_reg;
        res_ok_next       = res_ok_reg;
        res_entry_next    = res_entry_reg;
        m_ok_next         = m_ok_reg;
        m_entry_next      = m_entry_reg;
        m_pending_next    = m_pending_reg;
        m_dropped_next    = m_dropped_reg;
        m_latest_next     = m_latest_reg;
        m_valid_next      = m_valid_reg && !m_ready;
        ram_wr_en         = 1'b0;

        unique case (state_reg)
            ST_IDLE: begin
                if (s_valid) begin
                    cursor_next    = s_after_seq;
                    res_ok_next    = 1'b0;
                    res_entry_next = '0;
                    state_next     = ST_DONE;
                    unique case (s_req_type)
                        REQ_EMIT: begin
                            if (!is_dup) begin
                                last_known_next  = 1'b1;
                                last_status_next = status_in;
                                ram_wr_en        = 1'b1;
                                seq_counter_next = seq_counter_reg + SEQ_W'(1);
                                write_pos_next   = next_pos(write_pos_reg);
                                res_ok_next      = 1'b1;
                                res_entry_next   = ram_wr_data;
                                // Full ring: overwrite the oldest entry
                                if (is_full) begin
                                    read_pos_next     = next_pos(read_pos_reg);
                                    drop_counter_next = drop_counter_reg + SEQ_W'(1);
                                end else begin
                                    held_count_next = held_count_reg + CNT_W'(1);
                                end
                            end
                        end
                        REQ_POP: begin
                            if (held_count_reg != '0) begin
                                read_pos_next   = next_pos(read_pos_reg);
                                held_count_next = held_count_reg - CNT_W'(1);
                                state_next      = ST_POP;
                            end
                        end
                        REQ_GET: begin
                            if (held_count_reg != '0) begin
                                scan_idx_next  = next_pos(read_pos_reg);
                                scan_left_next = held_count_reg;
                                state_next     = ST_SCAN;
                            end
                        end
                        default: begin
                        end
                    endcase
                end
            end
            ST_POP: begin
                res_ok_next    = 1'b1;
                res_entry_next = ram_rd_data;
                state_next     = ST_DONE;
            end
            ST_SCAN: begin
                // RAM data is the entry whose address was issued in the previous cycle
                priority if (ram_rd_data.seq > cursor_reg) begin
                    res_ok_next    = 1'b1;
                    res_entry_next = ram_rd_data;
                    state_next     = ST_DONE;
                end else if (scan_left_reg == CNT_W'(1)) begin
                    state_next = ST_DONE;
                end else begin
                    scan_left_next = scan_left_reg - CNT_W'(1);
                    scan_idx_next  = next_pos(scan_idx_reg);
                end
            end
            ST_DONE: begin
                // Move result into the output register once it is free
                if (!m_valid_reg || m_ready) begin
                    m_valid_next   = 1'b1;
                    m_ok_next      = res_ok_reg;
                    m_entry_next   = res_entry_reg;
                    m_pending_next = PEND_W'(held_count_reg);
                    m_dropped_next = drop_counter_reg;
                    m_latest_next  = seq_counter_reg;
                    state_next     = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // Control registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg        <= ST_IDLE;
            write_pos_reg    <= '0;
            read_pos_reg     <= '0;
            held_count_reg   <= '0;
            drop_counter_reg <= '0;
            seq_counter_reg  <= '0;
            last_known_reg   <= 1'b0;
            last_status_reg  <= '0;
            scan_idx_reg     <= '0;
            scan_left_reg    <= '0;
            m_valid_reg      <= 1'b0;
        end else begin
            state_reg        <= state_next;
            write_pos_reg    <= write_pos_next;
            read_pos_reg     <= read_pos_next;
            held_count_reg   <= held_count_next;
            drop_counter_reg <= drop_counter_next;
            seq_counter_reg  <= seq_counter_next;
            last_known_reg   <= last_known_next;
            last_status_reg  <= last_status_next;
            scan_idx_reg     <= scan_idx_next;
            scan_left_reg    <= scan_left_next;
            m_valid_reg      <= m_valid_next;
        end
    end

    // Payload registers
    always_ff @(posedge aclk) begin
        cursor_reg    <= cursor_next;
        res_ok_reg    <= res_ok_next;
        res_entry_reg <= res_entry_next;
        m_ok_reg      <= m_ok_next;
        m_entry_reg   <= m_entry_next;
        m_pending_reg <= m_pending_next;
        m_dropped_reg <= m_dropped_next;
        m_latest_reg  <= m_latest_next;
    end

    assign m_valid             = m_valid_reg;
    assign m_ok                = m_ok_reg;
    assign m_entry_seq         = m_entry_reg.seq;
    assign m_entry_tick        = m_entry_reg.tick;
    assign m_entry_present     = m_entry_reg.status.present;
    assign m_entry_initialized = m_entry_reg.status.initialized;
    assign m_entry_link_up     = m_entry_reg.status.link_up;
    assign m_entry_speed       = m_entry_reg.status.speed;
    assign m_pending_count     = m_pending_reg;
    assign m_dropped_total     = m_dropped_reg;
    assign m_latest_sequence   = m_latest_reg;

    // Pointer consistency: read_pos + held_count wraps onto write_pos
    logic [SUM_W-1:0] pos_sum;
    logic [SUM_W-1:0] pos_wrap;
    assign pos_sum  = SUM_W'(read_pos_reg) + SUM_W'(held_count_reg);
    assign pos_wrap = (pos_sum >= SUM_W'(QUEUE_DEPTH)) ? pos_sum - SUM_W'(QUEUE_DEPTH)
                                                       : pos_sum;

    a_held_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        held_count_reg <= CNT_W'(QUEUE_DEPTH))
        else $error("held count above ring depth");

    a_ptr_consistent: assert property (@(posedge aclk) disable iff (!aresetn)
        pos_wrap == SUM_W'(write_pos_reg))
        else $error("ring pointers disagree with held count");

    a_scan_nonempty: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_SCAN) |-> (scan_left_reg != '0))
        else $error("scan running with nothing left");

    a_seq_step: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_valid && s_ready && (s_req_type == REQ_EMIT) && !is_dup)
        |=> (seq_counter_reg == $past(seq_counter_reg) + SEQ_W'(1)))
        else $error("recorded emit did not advance sequence");

    a_pop_empty_stays: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_valid && s_ready && (s_req_type == REQ_POP) && (held_count_reg == '0))
        |=> (held_count_reg == '0) && (state_reg == ST_DONE))
        else $error("pop on empty ring changed state");

endmodule
